// ===== sv/resource_deadlock_detector_top_defines.svh =====
// ----------------------------------------------------------------------------
// Resource deadlock detector assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_DEADLOCK_DETECTOR_TOP_DEFINES_SVH
`define RESOURCE_DEADLOCK_DETECTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector package
// Shared widths, codes, controller states and control bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdd_pkg;

  localparam int AMT_W         = 8;
  localparam int WORK_W        = 12;
  localparam int NUM_AMT       = 3;
  localparam int PIDX_W        = 3;
  localparam int COUNT_W       = 4;
  localparam int MASK_W        = 8;
  localparam int MAX_PROCESSES = 16;
  localparam int DEF_PROCESSES = 8;
  localparam int DEF_RESOURCES = 3;

  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  typedef logic [NUM_AMT-1:0][AMT_W-1:0] amt_vec_t;

  typedef enum logic {
    OP_AVAIL = 1'b0,
    OP_ROW   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic load_avail;
    logic load_row;
    logic det_init;
    logic scan_step;
    logic pass_restart;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic none_loaded;
    logic last_idx;
    logic progress;
  } status_t;

endpackage

// ===== sv/rdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector controller
// Sequences word loads, detection passes and the result report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdd_ctrl import rdd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    opcode_i,
  input  logic    last_row_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && (opcode_i == OP_ROW) && last_row_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.none_loaded) begin
          state_d = ST_REPORT;
        end else if (status_i.last_idx && !status_i.progress) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.load_avail = start_i && (opcode_i == OP_AVAIL);
        cmd_o.load_row   = start_i && (opcode_i == OP_ROW);
        cmd_o.det_init   = start_i && (opcode_i == OP_ROW) && last_row_i;
      end
      ST_SCAN: begin
        cmd_o.scan_step    = !status_i.none_loaded;
        cmd_o.pass_restart = !status_i.none_loaded && status_i.last_idx &&
                             status_i.progress;
      end
      ST_REPORT: begin
        cmd_o.capture = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/rdd_datapath.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector datapath
// Holds the process rows and work vector and evaluates one row per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdd_datapath import rdd_pkg::*; #(
  parameter int PROCESSES = DEF_PROCESSES,
  parameter int RESOURCES = DEF_RESOURCES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [PIDX_W-1:0]  process_index_i,
  input  amt_vec_t           amount_i,
  input  amt_vec_t           request_i,
  output status_t            status_o,
  output logic               done_o,
  output logic               deadlocked_o,
  output logic [COUNT_W-1:0] finished_count_o,
  output logic [MASK_W-1:0]  stuck_mask_o
);

  localparam int IdxW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CntW = $clog2(PROCESSES + 1);
  localparam int ExtW = $clog2(MAX_PROCESSES + 1);

  logic [RESOURCES-1:0][AMT_W-1:0]  alloc_q   [PROCESSES];
  logic [RESOURCES-1:0][AMT_W-1:0]  req_q     [PROCESSES];
  logic [RESOURCES-1:0][WORK_W-1:0] work_q, work_d;
  logic [PROCESSES-1:0]             fin_q;
  logic [IdxW-1:0]                  idx_q;
  logic [CntW-1:0]                  n_q;
  logic [CntW-1:0]                  cnt_q;
  logic                             progress_q;
  logic                             done_q;
  logic                             dead_q;
  logic [COUNT_W-1:0]               fcount_q;
  logic [MASK_W-1:0]                stuck_q;

  logic [ExtW-1:0]          pidx_ext;
  logic                     in_range;
  logic [IdxW-1:0]          waddr;
  logic                     fit;
  logic                     zero_alloc;
  logic                     fin_now;
  logic [MAX_PROCESSES-1:0] fin_ext;
  logic [MAX_PROCESSES-1:0] loaded;
  logic [MAX_PROCESSES-1:0] stuck_all;
  logic [ExtW-1:0]          cnt_ext;

  assign pidx_ext = ExtW'(process_index_i);
  assign in_range = pidx_ext < ExtW'(PROCESSES);
  assign waddr    = pidx_ext[IdxW-1:0];

  always_comb begin
    logic [WORK_W:0] sum;
    fit        = 1'b1;
    zero_alloc = 1'b1;
    work_d     = work_q;
    for (int j = 0; j < RESOURCES; j++) begin
      if (WORK_W'(req_q[idx_q][j]) > work_q[j]) begin
        fit = 1'b0;
      end
      if (alloc_q[idx_q][j] != '0) begin
        zero_alloc = 1'b0;
      end
    end
    fin_now = !fin_q[idx_q] && (fit || zero_alloc);
    for (int j = 0; j < RESOURCES; j++) begin
      sum = (WORK_W + 1)'(work_q[j]) + (WORK_W + 1)'(alloc_q[idx_q][j]);
      work_d[j] = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
    end
  end

  assign status_o.none_loaded = (n_q == '0);
  assign status_o.last_idx    = (CntW'(idx_q) + CntW'(1)) == n_q;
  assign status_o.progress    = progress_q || fin_now;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && in_range) begin
      for (int j = 0; j < RESOURCES; j++) begin
        alloc_q[waddr][j] <= amount_i[j];
        req_q[waddr][j]   <= request_i[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q     <= '0;
      fin_q      <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      cnt_q      <= '0;
      progress_q <= 1'b0;
    end else begin
      if (cmd_i.load_avail) begin
        for (int j = 0; j < RESOURCES; j++) begin
          work_q[j] <= WORK_W'(amount_i[j]);
        end
        n_q   <= '0;
        fin_q <= '0;
      end
      if (cmd_i.load_row && in_range && (n_q != CntW'(PROCESSES))) begin
        n_q <= n_q + CntW'(1);
      end
      if (cmd_i.det_init) begin
        fin_q      <= '0;
        cnt_q      <= '0;
        idx_q      <= '0;
        progress_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (fin_now) begin
          work_q        <= work_d;
          fin_q[idx_q]  <= 1'b1;
          cnt_q         <= cnt_q + CntW'(1);
        end
        if (cmd_i.pass_restart) begin
          idx_q      <= '0;
          progress_q <= 1'b0;
        end else begin
          idx_q      <= idx_q + IdxW'(1);
          progress_q <= progress_q || fin_now;
        end
      end
      if (cmd_i.capture) begin
        n_q <= '0;
      end
    end
  end

  always_comb begin
    fin_ext = MAX_PROCESSES'(fin_q);
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      loaded[i] = ExtW'(i) < ExtW'(n_q);
    end
    stuck_all = loaded & ~fin_ext;
    cnt_ext   = ExtW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.capture;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dead_q   <= |stuck_all;
      fcount_q <= (cnt_ext > ExtW'(15)) ? COUNT_W'(15) : cnt_ext[COUNT_W-1:0];
      stuck_q  <= stuck_all[MASK_W-1:0];
    end
  end

  assign done_o           = done_q;
  assign deadlocked_o     = dead_q;
  assign finished_count_o = fcount_q;
  assign stuck_mask_o     = stuck_q;

endmodule

// ===== sv/resource_deadlock_detector_top.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector
// Loads an available vector and process rows, then finds the stuck set.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                   | Ports
//  ---------+-----------------------------+--------------------------------
//  input    | start high while busy low   | opcode, index, last, amounts
//  result   | done_o strobe, one cycle    | deadlocked, count, stuck mask
//
// Each load word is accepted while busy is low; busy stays low between words.
// A row word with last_row_i set raises busy for the detection passes and
// the report, where n is the number of loaded rows and passes is at most
// n + 1; one stored row is evaluated per cycle. With no row loaded, busy
// covers only the scan and report states. done_o follows as busy falls.
// Reset clears the controller, the work vector and the row count.
// The receiver cannot stall; the result is valid for the done_o cycle only.
`timescale 1ns / 1ps

module resource_deadlock_detector_top import rdd_pkg::*; #(
  parameter int PROCESSES = DEF_PROCESSES,
  parameter int RESOURCES = DEF_RESOURCES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [PIDX_W-1:0]  process_index_i,
  input  logic               last_row_i,
  input  logic [AMT_W-1:0]   amount_0_i,
  input  logic [AMT_W-1:0]   amount_1_i,
  input  logic [AMT_W-1:0]   amount_2_i,
  input  logic [AMT_W-1:0]   request_0_i,
  input  logic [AMT_W-1:0]   request_1_i,
  input  logic [AMT_W-1:0]   request_2_i,
  output logic               done_o,
  output logic               deadlocked_o,
  output logic [COUNT_W-1:0] finished_count_o,
  output logic [MASK_W-1:0]  stuck_mask_o
);

  cmd_t     cmd;
  status_t  status;
  amt_vec_t amounts;
  amt_vec_t requests;

  assign amounts  = {amount_2_i, amount_1_i, amount_0_i};
  assign requests = {request_2_i, request_1_i, request_0_i};

  rdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .opcode_i   (opcode_i),
    .last_row_i (last_row_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  rdd_datapath #(
    .PROCESSES (PROCESSES),
    .RESOURCES (RESOURCES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .process_index_i  (process_index_i),
    .amount_i         (amounts),
    .request_i        (requests),
    .status_o         (status),
    .done_o           (done_o),
    .deadlocked_o     (deadlocked_o),
    .finished_count_o (finished_count_o),
    .stuck_mask_o     (stuck_mask_o)
  );

endmodule

// ===== sv/rdd_checker.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector port checker
// Watches the top-level ports for launch, busy and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resource_deadlock_detector_top_defines.svh"

module rdd_checker import rdd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               opcode_i,
  input logic               last_row_i,
  input logic               done_o,
  input logic               deadlocked_o,
  input logic [MASK_W-1:0]  stuck_mask_o
);

  logic launch;

  assign launch = start && !busy && (opcode_i == OP_ROW) && last_row_i;

  `RDD_ASSERT_NEXT(a_launch_busy, clk_i, rst_ni, launch, busy, "detection did not raise busy")
  `RDD_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy, "result word shown while busy")
  `RDD_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")
  `RDD_ASSERT_SAME(a_mask_dead, clk_i, rst_ni, done_o && (stuck_mask_o != '0), deadlocked_o,
    "stuck processes reported without deadlock")

endmodule

bind resource_deadlock_detector_top rdd_checker u_rdd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .opcode_i     (opcode_i),
  .last_row_i   (last_row_i),
  .done_o       (done_o),
  .deadlocked_o (deadlocked_o),
  .stuck_mask_o (stuck_mask_o)
);

// ===== verif/resource_deadlock_detector_top_test.sv =====
// ----------------------------------------------------------------------------
// Resource deadlock detector testbench
// Drives available vectors and process rows through the command port and
// checks every detection report against a cycle-free prediction of the
// finished set, the stuck mask and the deadlock flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resource_deadlock_detector_top_test;
  import rdd_pkg::*;

  typedef struct {
    opcode_e           op;
    logic [PIDX_W-1:0] idx;
    logic              last;
    amt_vec_t          amt;
    amt_vec_t          req;
  } load_word_t;

  typedef struct packed {
    logic               deadlocked;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  mask;
  } stuck_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode_i = 1'b0;
  logic [PIDX_W-1:0]  process_index_i = '0;
  logic               last_row_i = 1'b0;
  logic [AMT_W-1:0]   amount_0_i = '0;
  logic [AMT_W-1:0]   amount_1_i = '0;
  logic [AMT_W-1:0]   amount_2_i = '0;
  logic [AMT_W-1:0]   request_0_i = '0;
  logic [AMT_W-1:0]   request_1_i = '0;
  logic [AMT_W-1:0]   request_2_i = '0;
  logic               done_o;
  logic               deadlocked_o;
  logic [COUNT_W-1:0] finished_count_o;
  logic [MASK_W-1:0]  stuck_mask_o;

  amt_vec_t                 held_alloc [DEF_PROCESSES];
  amt_vec_t                 held_req [DEF_PROCESSES];
  logic [WORK_W-1:0]        pool [NUM_AMT];
  logic [DEF_PROCESSES-1:0] done_set = '0;
  int                       rows_held = 0;

  stuck_report_t verdict_q[$];
  stuck_report_t want;
  int            errors = 0;
  int            words_sent = 0;
  int            reports_seen = 0;
  int            deadlocks_seen = 0;
  int            gap_pct = 0;

  resource_deadlock_detector_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .process_index_i  (process_index_i),
    .last_row_i       (last_row_i),
    .amount_0_i       (amount_0_i),
    .amount_1_i       (amount_1_i),
    .amount_2_i       (amount_2_i),
    .request_0_i      (request_0_i),
    .request_1_i      (request_1_i),
    .request_2_i      (request_2_i),
    .done_o           (done_o),
    .deadlocked_o     (deadlocked_o),
    .finished_count_o (finished_count_o),
    .stuck_mask_o     (stuck_mask_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic stuck_report_t run_detection();
    stuck_report_t    r;
    logic             moved;
    logic             fits;
    logic [WORK_W:0]  sum;
    r = '0;
    done_set = '0;
    for (int p = 0; p < rows_held; p++) begin
      if (held_alloc[p] == '0) done_set[p] = 1'b1;
    end
    do begin
      moved = 1'b0;
      for (int p = 0; p < rows_held; p++) begin
        if (!done_set[p]) begin
          fits = 1'b1;
          for (int j = 0; j < NUM_AMT; j++) begin
            if (held_req[p][j] > pool[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < NUM_AMT; j++) begin
              sum = {1'b0, pool[j]} + held_alloc[p][j];
              pool[j] = (sum > WORK_MAX) ? WORK_MAX : sum[WORK_W-1:0];
            end
            done_set[p] = 1'b1;
            moved = 1'b1;
          end
        end
      end
    end while (moved);
    for (int p = 0; p < rows_held; p++) begin
      if (done_set[p]) r.count = r.count + 1'b1;
      else r.mask[p] = 1'b1;
    end
    r.deadlocked = |r.mask;
    rows_held = 0;
    return r;
  endfunction

  function automatic void predict_word(input load_word_t w);
    if (w.op == OP_AVAIL) begin
      for (int j = 0; j < NUM_AMT; j++) pool[j] = {{(WORK_W-AMT_W){1'b0}}, w.amt[j]};
      rows_held = 0;
      done_set = '0;
    end else begin
      held_alloc[w.idx] = w.amt;
      held_req[w.idx] = w.req;
      if (rows_held < DEF_PROCESSES) rows_held++;
      if (w.last) verdict_q.push_back(run_detection());
    end
  endfunction

  function automatic load_word_t mk_avail(input int a0, a1, a2, input logic last);
    load_word_t w;
    w.op = OP_AVAIL;
    w.idx = PIDX_W'($urandom);
    w.last = last;
    w.amt = {AMT_W'(a2), AMT_W'(a1), AMT_W'(a0)};
    w.req = amt_vec_t'($urandom);
    return w;
  endfunction

  function automatic load_word_t mk_row(input int idx, input logic last,
                                        input int a0, a1, a2, r0, r1, r2);
    load_word_t w;
    w.op = OP_ROW;
    w.idx = PIDX_W'(idx);
    w.last = last;
    w.amt = {AMT_W'(a2), AMT_W'(a1), AMT_W'(a0)};
    w.req = {AMT_W'(r2), AMT_W'(r1), AMT_W'(r0)};
    return w;
  endfunction

  function automatic int rand_amount(input int mode);
    case (mode)
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 255);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic send_word(input load_word_t w);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= w.op;
    process_index_i <= w.idx;
    last_row_i <= w.last;
    amount_0_i <= w.amt[0];
    amount_1_i <= w.amt[1];
    amount_2_i <= w.amt[2];
    request_0_i <= w.req[0];
    request_1_i <= w.req[1];
    request_2_i <= w.req[2];
    do @(posedge clk_i); while (busy);
    predict_word(w);
    words_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      reports_seen++;
      if (deadlocked_o) deadlocks_seen++;
      if (verdict_q.size() == 0) begin
        $error("report arrived with no detection pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (deadlocked_o !== want.deadlocked) begin
          $error("deadlocked: expected %0d, got %0d", want.deadlocked, deadlocked_o);
          errors++;
        end
        if (finished_count_o !== want.count) begin
          $error("finished_count: expected %0d, got %0d", want.count, finished_count_o);
          errors++;
        end
        if (stuck_mask_o !== want.mask) begin
          $error("stuck_mask: expected %h, got %h", want.mask, stuck_mask_o);
          errors++;
        end
      end
    end
  end

  // Writes every row once, then a ninth row so that the row count saturates.
  task automatic test_saturated_batch();
    send_word(mk_avail(2, 2, 2, 1'b0));
    for (int p = 0; p < DEF_PROCESSES; p++) begin
      send_word(mk_row(p, 1'b0, p % 3, 1, p % 2, p % 4, 2, 1));
    end
    send_word(mk_row(DEF_PROCESSES - 1, 1'b1, 3, 0, 1, 2, 2, 2));
  endtask

  task automatic test_field_extremes();
    send_word(mk_avail(0, 0, 0, 1'b1));
    send_word(mk_row(0, 1'b1, 255, 255, 255, 255, 255, 255));
    send_word(mk_avail(255, 255, 255, 1'b0));
    send_word(mk_row(0, 1'b1, 255, 255, 255, 255, 255, 255));
  endtask

  task automatic test_zero_allocation();
    send_word(mk_avail(0, 0, 0, 1'b0));
    send_word(mk_row(0, 1'b1, 0, 0, 0, 255, 255, 255));
  endtask

  // Each process can only run after the one loaded behind it has released.
  task automatic test_multi_pass();
    send_word(mk_avail(0, 0, 0, 1'b0));
    send_word(mk_row(0, 1'b0, 1, 0, 0, 0, 0, 1));
    send_word(mk_row(1, 1'b0, 0, 0, 1, 0, 1, 0));
    send_word(mk_row(2, 1'b1, 0, 1, 0, 0, 0, 0));
  endtask

  task automatic test_circular_wait();
    send_word(mk_avail(0, 0, 0, 1'b0));
    send_word(mk_row(0, 1'b0, 1, 0, 0, 0, 1, 0));
    send_word(mk_row(1, 1'b1, 0, 1, 0, 1, 0, 0));
  endtask

  // A row after a report, with no new available vector, uses the kept work.
  task automatic test_kept_work();
    send_word(mk_row(5, 1'b1, 1, 1, 1, 0, 0, 0));
  endtask

  task automatic test_random_batches(input int n_words, input int pct);
    int base;
    int kind;
    int mode;
    int rows;
    int idx;
    base = words_sent;
    gap_pct = pct;
    while (words_sent - base < n_words) begin
      kind = $urandom_range(0, 99);
      mode = $urandom_range(0, 2);
      if (kind < 6) begin
        if ($urandom_range(0, 1)) begin
          send_word(mk_avail(rand_amount(1), rand_amount(1), rand_amount(1),
                             1'($urandom)));
        end else begin
          send_word(mk_row($urandom_range(0, 7), 1'($urandom), rand_amount(mode),
                           rand_amount(mode), rand_amount(mode), rand_amount(mode),
                           rand_amount(mode), rand_amount(mode)));
        end
      end else begin
        if (kind >= 12) begin
          send_word(mk_avail(rand_amount(mode), rand_amount(mode), rand_amount(mode),
                             1'($urandom)));
        end
        rows = (kind < 18) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        for (int r = 0; r < rows; r++) begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : r % DEF_PROCESSES;
          if ($urandom_range(0, 99) < 15) begin
            send_word(mk_row(idx, r == rows - 1, 0, 0, 0, rand_amount(1),
                             rand_amount(1), rand_amount(1)));
          end else begin
            send_word(mk_row(idx, r == rows - 1, rand_amount(mode), rand_amount(mode),
                             rand_amount(mode), rand_amount(mode), rand_amount(mode),
                             rand_amount(mode)));
          end
        end
      end
    end
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_saturated_batch();
    test_field_extremes();
    test_zero_allocation();
    test_multi_pass();
    test_circular_wait();
    test_kept_work();
    test_random_batches(570, 0);
    test_random_batches(570, 67);
    test_random_batches(570, 34);

    gap_pct = 0;
    start <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d detection reports never arrived", verdict_q.size());
      errors++;
    end

    $display("Sent %0d load words and checked %0d detection reports,", words_sent,
             reports_seen);
    $display("%0d of which flagged a deadlock, with and without sender gaps.",
             deadlocks_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rdd_pkg.sv
sv/rdd_ctrl.sv
sv/rdd_datapath.sv
sv/resource_deadlock_detector_top.sv
sv/rdd_checker.sv
verif/resource_deadlock_detector_top_test.sv
